@@ rtl/p2ansi_pkg.sv @@
// Shared types and constants for the truecolor text encoder.
// No dependencies; every other file of the block imports it.
package p2ansi_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PREFIX_BYTES = 4'd0,
      CSR_PREFIX_COUNT = 4'd1,
      CSR_SUFFIX_BYTES = 4'd2,
      CSR_SUFFIX_COUNT = 4'd3
   } p2ansi_csr_type;

   // Reset values of the configuration registers.
   localparam logic [63:0] PREFIX_RESET       = 64'h003B_323B_3834_5B1B;
   localparam logic [3:0]  PREFIX_COUNT_RESET = 4'd7;
   localparam logic [63:0] SUFFIX_RESET       = 64'h0000_0000_0000_006D;
   localparam logic [3:0]  SUFFIX_COUNT_RESET = 4'd1;
   localparam logic [3:0]  COUNT_MAX          = 4'd8;

   // Characters of the text stream.
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;

   // Index of the last compare and subtract step of the decimal converter.
   localparam logic [2:0] CONV_LAST_STEP = 3'd5;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_PREFIX,
      S_LOAD,
      S_CONV,
      S_HUND,
      S_TENS,
      S_UNITS,
      S_SEMI,
      S_SUFFIX,
      S_SPACE,
      S_NEWLINE,
      S_NUL
   } p2ansi_state_type;

   // Decimal digits of one color channel.
   typedef struct packed {
      logic [1:0] hund;
      logic [3:0] tens;
      logic [3:0] units;
   } p2ansi_digits_type;

   // Weight that the converter tries to subtract at each step: two steps
   // for the hundreds digit, then four for the tens digit, bit by bit.
   function automatic logic [7:0] p2ansi_weight(input logic [2:0] step);
      logic [7:0] w;
      case (step)
         3'd0:    w = 8'd200;
         3'd1:    w = 8'd100;
         3'd2:    w = 8'd80;
         3'd3:    w = 8'd40;
         3'd4:    w = 8'd20;
         default: w = 8'd10;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/p2ansi_if.sv @@
// Valid/ready channel interfaces of the truecolor text encoder.
// Depends on p2ansi_pkg for the configuration port widths.

// Pixel request channel.
interface p2ansi_pixel_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_color;
   logic        row_end;
   logic        frame_end;

   modport source (output valid, pixel_color, row_end, frame_end, input ready);
   modport sink   (input valid, pixel_color, row_end, frame_end, output ready);
endinterface

// Text byte result channel.
interface p2ansi_text_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       frame_done;

   modport source (output valid, text_byte, frame_done, input ready);
   modport sink   (input valid, text_byte, frame_done, output ready);
endinterface

// Configuration write channel.
interface p2ansi_csr_if
   import p2ansi_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/p2ansi_digits.sv @@
// Iterative binary to decimal converter for one 8-bit color channel.
// One compare and subtract per cycle; depends on p2ansi_pkg.
module p2ansi_digits
   import p2ansi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [7:0]        value,
   output logic              done,
   output p2ansi_digits_type digits
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] rem_ff, rem_in;
   logic [5:0] acc_ff, acc_in;
   logic [7:0] weight;
   logic [2:0] bit_sel;

   assign weight  = p2ansi_weight(step_ff);
   assign bit_sel = CONV_LAST_STEP - step_ff;

   // One step: subtract the weight if it fits and record the digit bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = value;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= weight) begin
            rem_in          = rem_ff - weight;
            acc_in[bit_sel] = 1'b1;
         end
         step_in = step_ff + 3'd1;
         if (step_ff == CONV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Working value and digit bits carry no reset.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign done         = done_ff;
   assign digits.hund  = acc_ff[5:4];
   assign digits.tens  = acc_ff[3:0];
   assign digits.units = rem_ff[3:0];

endmodule

@@ rtl/pixel_to_ansi_truecolor_text.sv @@
// Top level of the truecolor text encoder: sequencer, registers, output stage.
// Depends on p2ansi_pkg, p2ansi_if.sv and p2ansi_digits.
//
//   Channel | Role   | Payload                                  | Accepted when
//   req     | sink   | pixel_color[23:0], row_end, frame_end    | valid && ready
//   rsp     | source | text_byte[7:0], frame_done               | valid && ready
//   csr     | sink   | index[3:0], data[63:0]                   | valid && ready
//
// A pixel without a color change sends a space, a newline and a NUL as its flags ask.
// A pixel with an escape adds prefix and suffix bytes plus the decimal digits of
// each color channel, set by the shared compare and subtract converter.
// A stalled output holds the sequencer at its current byte; a new pixel is
// taken only after the last byte of the previous one sits in the output stage.
// Reset is synchronous and restores the default escape strings.
module pixel_to_ansi_truecolor_text
   import p2ansi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   p2ansi_pixel_if.sink   req_bus,
   p2ansi_text_if.source  rsp_bus,
   p2ansi_csr_if.sink     csr_bus
);

   // Configuration registers.
   logic [63:0] prefix_ff, suffix_ff;
   logic [3:0]  prefix_count_ff, suffix_count_ff;
   logic [3:0]  prefix_eff, suffix_eff;

   // Pixel state and the current request.
   logic [23:0] prev_color_ff, prev_color_in;
   logic        at_start_ff, at_start_in;
   logic [23:0] color_ff, color_in;
   logic        row_end_ff, row_end_in;
   logic        frame_end_ff, frame_end_in;

   // Sequencer.
   p2ansi_state_type state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic [1:0] chan_ff, chan_in;

   // Output stage.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       out_free;

   // Converter hookup.
   logic              conv_start;
   logic              conv_done;
   logic [7:0]        conv_value;
   p2ansi_digits_type digits;

   logic req_fire, csr_fire;
   logic emit;
   logic [7:0] emit_byte;
   logic emit_done;
   logic escape;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign escape   = at_start_ff || (req_bus.pixel_color != prev_color_ff);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   // Counts above eight send eight bytes.
   assign prefix_eff = (prefix_count_ff > COUNT_MAX) ? COUNT_MAX : prefix_count_ff;
   assign suffix_eff = (suffix_count_ff > COUNT_MAX) ? COUNT_MAX : suffix_count_ff;

   // Channel byte handed to the converter.
   always_comb begin
      case (chan_ff)
         2'd0:    conv_value = color_ff[23:16];
         2'd1:    conv_value = color_ff[15:8];
         default: conv_value = color_ff[7:0];
      endcase
   end

   assign conv_start = (state_ff == S_LOAD);

   p2ansi_digits u_digits (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (conv_value),
      .done   (conv_done),
      .digits (digits)
   );

   // Next state, emitted byte and pixel state updates.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      chan_in       = chan_ff;
      prev_color_in = prev_color_ff;
      at_start_in   = at_start_ff;
      color_in      = color_ff;
      row_end_in    = row_end_ff;
      frame_end_in  = frame_end_ff;
      emit          = 1'b0;
      emit_byte     = CHAR_NUL;
      emit_done     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               color_in     = req_bus.pixel_color;
               row_end_in   = req_bus.row_end;
               frame_end_in = req_bus.frame_end;
               idx_in       = '0;
               chan_in      = '0;
               if (escape) begin
                  prev_color_in = req_bus.pixel_color;
                  at_start_in   = 1'b0;
                  state_in      = (prefix_eff != 4'd0) ? S_PREFIX : S_LOAD;
               end else begin
                  state_in = S_SPACE;
               end
               // A frame end returns the color memory to its reset value.
               if (req_bus.frame_end) begin
                  prev_color_in = '0;
                  at_start_in   = 1'b1;
               end
            end
         end
         S_PREFIX: begin
            emit      = 1'b1;
            emit_byte = prefix_ff[{idx_ff, 3'b000} +: 8];
            if (out_free) begin
               idx_in = idx_ff + 3'd1;
               if ({1'b0, idx_ff} == prefix_eff - 4'd1) begin
                  idx_in   = '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_CONV;
         end
         S_CONV: begin
            if (conv_done) begin
               state_in = S_HUND;
            end
         end
         S_HUND: begin
            // Leading zero of the hundreds is dropped.
            if (digits.hund == 2'd0) begin
               state_in = S_TENS;
            end else begin
               emit      = 1'b1;
               emit_byte = CHAR_ZERO | {6'd0, digits.hund};
               if (out_free) begin
                  state_in = S_TENS;
               end
            end
         end
         S_TENS: begin
            // Tens are dropped only when the hundreds were dropped too.
            if (digits.hund == 2'd0 && digits.tens == 4'd0) begin
               state_in = S_UNITS;
            end else begin
               emit      = 1'b1;
               emit_byte = CHAR_ZERO | {4'd0, digits.tens};
               if (out_free) begin
                  state_in = S_UNITS;
               end
            end
         end
         S_UNITS: begin
            emit      = 1'b1;
            emit_byte = CHAR_ZERO | {4'd0, digits.units};
            if (out_free) begin
               if (chan_ff == 2'd2) begin
                  state_in = (suffix_eff != 4'd0) ? S_SUFFIX : S_SPACE;
               end else begin
                  state_in = S_SEMI;
               end
            end
         end
         S_SEMI: begin
            emit      = 1'b1;
            emit_byte = CHAR_SEMI;
            if (out_free) begin
               chan_in  = chan_ff + 2'd1;
               state_in = S_LOAD;
            end
         end
         S_SUFFIX: begin
            emit      = 1'b1;
            emit_byte = suffix_ff[{idx_ff, 3'b000} +: 8];
            if (out_free) begin
               idx_in = idx_ff + 3'd1;
               if ({1'b0, idx_ff} == suffix_eff - 4'd1) begin
                  idx_in   = '0;
                  state_in = S_SPACE;
               end
            end
         end
         S_SPACE: begin
            emit      = 1'b1;
            emit_byte = CHAR_SPACE;
            if (out_free) begin
               state_in = (row_end_ff || frame_end_ff) ? S_NEWLINE : S_IDLE;
            end
         end
         S_NEWLINE: begin
            emit      = 1'b1;
            emit_byte = CHAR_NEWLINE;
            if (out_free) begin
               state_in = frame_end_ff ? S_NUL : S_IDLE;
            end
         end
         S_NUL: begin
            emit      = 1'b1;
            emit_byte = CHAR_NUL;
            emit_done = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads when empty or when its byte is being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_done_in  = emit_done;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.text_byte  = rsp_byte_ff;
   assign rsp_bus.frame_done = rsp_done_ff;

   // Control and pixel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         chan_ff       <= '0;
         prev_color_ff <= '0;
         at_start_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         chan_ff       <= chan_in;
         prev_color_ff <= prev_color_in;
         at_start_ff   <= at_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request and output payload.
   always_ff @(posedge clock) begin
      color_ff     <= color_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff       <= PREFIX_RESET;
         prefix_count_ff <= PREFIX_COUNT_RESET;
         suffix_ff       <= SUFFIX_RESET;
         suffix_count_ff <= SUFFIX_COUNT_RESET;
      end else if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_PREFIX_BYTES: prefix_ff       <= csr_bus.data;
            CSR_PREFIX_COUNT: prefix_count_ff <= csr_bus.data[3:0];
            CSR_SUFFIX_BYTES: suffix_ff       <= csr_bus.data;
            CSR_SUFFIX_COUNT: suffix_count_ff <= csr_bus.data[3:0];
            default: ;
         endcase
      end
   end

   // The frame marker rides only on the NUL character.
   a_done_on_nul: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_byte_ff == CHAR_NUL))
      else $error("frame_done set on a byte other than NUL");

   // The converter finishes only while the sequencer waits for it.
   a_conv_in_wait: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == S_CONV))
      else $error("converter finished outside its wait state");

   // Converted digits are decimal.
   a_digits_range: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (digits.hund <= 2'd2 && digits.tens <= 4'd9 &&
                     digits.units <= 4'd9))
      else $error("converter produced a digit out of range");

   // A pixel request always starts work that leaves the idle state.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE && !req_bus.ready))
      else $error("sequencer stayed idle after a pixel request");

endmodule

@@ sim/tb_pixel_to_ansi_truecolor_text.sv @@
// Self-checking testbench for pixel_to_ansi_truecolor_text: drives pixel requests and
// register writes, predicts the terminal text stream and checks every text byte.
// Depends on rtl/p2ansi_pkg.sv, rtl/p2ansi_if.sv and the block's RTL.
module tb_pixel_to_ansi_truecolor_text
   import p2ansi_pkg::*;
   ;

   localparam int STALL_LIMIT       = 3000;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES      = 8;
   localparam int RANDOM_PHASES     = 4;
   localparam int PIXELS_PER_PHASE  = 50;

   typedef struct packed {
      logic [23:0] color;
      logic        row_end;
      logic        frame_end;
   } pixel_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       frame_done;
   } text_char_type;

   logic clock;
   logic reset = 1'b1;

   // Signals driven by the testbench; all start at known values.
   logic        pix_valid     = 1'b0;
   logic [23:0] pix_color     = '0;
   logic        pix_row_end   = 1'b0;
   logic        pix_frame_end = 1'b0;
   logic        rsp_ready     = 1'b0;
   logic        csr_valid     = 1'b0;
   logic [3:0]  csr_index     = '0;
   logic [63:0] csr_data      = '0;
   logic        idle_enabled  = 1'b0;
   logic        stall_armed   = 1'b0;

   p2ansi_pixel_if pix_if ();
   p2ansi_text_if  txt_if ();
   p2ansi_csr_if   csr_if ();

   assign pix_if.valid       = pix_valid;
   assign pix_if.pixel_color = pix_color;
   assign pix_if.row_end     = pix_row_end;
   assign pix_if.frame_end   = pix_frame_end;
   assign txt_if.ready       = rsp_ready;
   assign csr_if.valid       = csr_valid;
   assign csr_if.index       = csr_index;
   assign csr_if.data        = csr_data;

   pixel_to_ansi_truecolor_text i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (pix_if),
      .rsp_bus (txt_if),
      .csr_bus (csr_if)
   );

   // Encoder state as the predictor sees it, starting from the reset values.
   logic [63:0] cfg_prefix_bytes = PREFIX_RESET;
   logic [3:0]  cfg_prefix_count = PREFIX_COUNT_RESET;
   logic [63:0] cfg_suffix_bytes = SUFFIX_RESET;
   logic [3:0]  cfg_suffix_count = SUFFIX_COUNT_RESET;
   logic [23:0] pred_color       = '0;
   logic        frame_start      = 1'b1;

   pixel_type     pixel_backlog[$];
   text_char_type expected_chars[$];
   pixel_type     pix_item;
   logic [23:0] gen_color = '0;

   int send_gap      = 0;
   int recv_gap      = 0;
   int stall_left    = 0;
   logic long_stall_done = 1'b0;
   int mismatches    = 0;
   int pixels_sent   = 0;
   int chars_checked = 0;
   int frames_seen   = 0;
   int csr_writes    = 0;
   int settings_used = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Text prediction.
   function void append_char(input logic [7:0] ch, input logic done);
      expected_chars.push_back('{text_byte: ch, frame_done: done});
   endfunction

   function void append_string(input logic [63:0] bytes, input logic [3:0] count);
      logic [3:0] n;
      n = (count > COUNT_MAX) ? COUNT_MAX : count;
      for (int i = 0; i < n; i++)
         append_char(bytes[i*8 +: 8], 1'b0);
   endfunction

   // Unpadded decimal: leading zero digits are dropped, a lone zero is kept.
   function void append_decimal(input logic [7:0] value);
      logic [7:0] hund, tens, units;
      hund  = value / 8'd100;
      tens  = (value / 8'd10) % 8'd10;
      units = value % 8'd10;
      if (hund != 0)
         append_char(CHAR_ZERO + hund, 1'b0);
      if (hund != 0 || tens != 0)
         append_char(CHAR_ZERO + tens, 1'b0);
      append_char(CHAR_ZERO + units, 1'b0);
   endfunction

   function void encode_pixel(input pixel_type px);
      if (frame_start || px.color != pred_color) begin
         append_string(cfg_prefix_bytes, cfg_prefix_count);
         append_decimal(px.color[23:16]);
         append_char(CHAR_SEMI, 1'b0);
         append_decimal(px.color[15:8]);
         append_char(CHAR_SEMI, 1'b0);
         append_decimal(px.color[7:0]);
         append_string(cfg_suffix_bytes, cfg_suffix_count);
         pred_color  = px.color;
         frame_start = 1'b0;
      end
      append_char(CHAR_SPACE, 1'b0);
      // A frame end closes the row even without a row end.
      if (px.row_end || px.frame_end)
         append_char(CHAR_NEWLINE, 1'b0);
      if (px.frame_end) begin
         append_char(CHAR_NUL, 1'b1);
         pred_color  = '0;
         frame_start = 1'b1;
      end
   endfunction

   // Stimulus helpers.
   function void queue_pixel(input logic [23:0] color, input logic row_end,
                             input logic frame_end);
      pixel_backlog.push_back('{color: color, row_end: row_end, frame_end: frame_end});
   endfunction

   // Well-formed frames with random sizes and colors, with some stray flags mixed in.
   function void queue_random_frames(input int n_items);
      int added, rows, width;
      logic row_last, frame_last;
      added = 0;
      while (added < n_items) begin
         rows = $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            width = $urandom_range(1, 6);
            for (int p = 0; p < width; p++) begin
               row_last   = (p == width - 1);
               frame_last = row_last && (r == rows - 1);
               // Repeats are frequent so that the no-change path gets exercised.
               case ($urandom_range(0, 6))
                  0, 1, 2: ;
                  3: gen_color = 24'($urandom);
                  4: gen_color = {8'($urandom_range(0, 9)), 8'($urandom_range(10, 99)),
                                  8'($urandom_range(100, 255))};
                  5: gen_color = {8'($urandom_range(100, 255)), 8'($urandom_range(0, 9)),
                                  8'($urandom_range(0, 99))};
                  default: gen_color = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
               endcase
               if ($urandom_range(0, 9) == 0)
                  queue_pixel(gen_color, 1'($urandom), 1'($urandom));
               else if (frame_last && $urandom_range(0, 3) == 0)
                  queue_pixel(gen_color, 1'b0, 1'b1);
               else
                  queue_pixel(gen_color, row_last, frame_last);
               added++;
            end
         end
      end
   endfunction

   // One register write; the predictor copy is updated when the request is taken.
   task automatic csr_write(input logic [3:0] index, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (index)
         CSR_PREFIX_BYTES: cfg_prefix_bytes = value;
         CSR_PREFIX_COUNT: cfg_prefix_count = value[3:0];
         CSR_SUFFIX_BYTES: cfg_suffix_bytes = value;
         CSR_SUFFIX_COUNT: cfg_suffix_count = value[3:0];
         default: ;
      endcase
   endtask

   // Wait until every pixel is taken and every text byte has come out.
   // The check runs on the falling edge, once the driver's updates have settled.
   task automatic wait_idle();
      @(negedge clock);
      while (pixel_backlog.size() != 0 || pix_valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pixel request driver with random gaps after a request.
   always @(posedge clock) begin
      if (reset) begin
         pix_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (pix_valid && pix_if.ready) begin
            encode_pixel(pix_item);
            pixels_sent++;
         end
         if (!pix_valid || pix_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               pix_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               pix_item = pixel_backlog.pop_front();
               pix_valid     <= 1'b1;
               pix_color     <= pix_item.color;
               pix_row_end   <= pix_item.row_end;
               pix_frame_end <= pix_item.frame_end;
               if (idle_enabled && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 15);
            end else begin
               pix_valid <= 1'b0;
            end
         end
      end
   end

   // Text monitor: checks each byte against the oldest prediction and drives ready.
   always @(posedge clock) begin : text_monitor
      text_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (txt_if.valid && rsp_ready) begin
            if (txt_if.frame_done)
               frames_seen++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected text byte, expected none, actual 0x%02h done %0b",
                        $time, txt_if.text_byte, txt_if.frame_done);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (txt_if.text_byte !== want.text_byte) begin
                  $display("%0t: text_byte mismatch, expected 0x%02h, actual 0x%02h",
                           $time, want.text_byte, txt_if.text_byte);
                  mismatches++;
               end
               if (txt_if.frame_done !== want.frame_done) begin
                  $display("%0t: frame_done mismatch, expected %0b, actual %0b",
                           $time, want.frame_done, txt_if.frame_done);
                  mismatches++;
               end
            end
         end
         // One long hold-off so that the block fills up and stalls its input.
         if (stall_armed && !long_stall_done) begin
            long_stall_done = 1'b1;
            stall_left = LONG_STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enabled && $urandom_range(0, 9) == 0)
               recv_gap = $urandom_range(1, 15);
         end
      end
   end

   // Watchdog: ends the run when no request of any channel moves for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((pix_valid && pix_if.ready) || (txt_if.valid && rsp_ready) ||
             (csr_valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: timeout, no request accepted for %0d cycles, %0d bytes outstanding",
               $time, STALL_LIMIT, expected_chars.size());
      $display("** pixel_to_ansi_truecolor_text: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset strings: frame start, repeats, digit patterns, frame ends.
      queue_pixel(24'h000000, 1'b0, 1'b0);
      queue_pixel(24'h000000, 1'b0, 1'b0);
      queue_pixel(24'hFFFFFF, 1'b1, 1'b0);
      queue_pixel(24'h640A09, 1'b0, 1'b0);
      queue_pixel(24'h640A09, 1'b0, 1'b0);
      queue_pixel(24'h6E0105, 1'b1, 1'b0);
      queue_pixel(24'hC8FF00, 1'b1, 1'b1);
      queue_pixel(24'h000000, 1'b0, 1'b0);
      queue_pixel(24'h123456, 1'b0, 1'b1);
      queue_pixel(24'h000000, 1'b0, 1'b1);
      queue_pixel(24'h000000, 1'b0, 1'b0);
      wait_idle();

      // Counts above eight, all-ones prefix, all-zero suffix, an ignored index.
      csr_write(CSR_PREFIX_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_PREFIX_COUNT, 64'h0000_0000_0000_000F);
      csr_write(CSR_SUFFIX_BYTES, 64'h0000_0000_0000_0000);
      csr_write(CSR_SUFFIX_COUNT, 64'h0000_0000_0000_0009);
      csr_write(4'(CSR_SUFFIX_COUNT) + 4'($urandom_range(1, 12)), {$urandom, $urandom});
      settings_used++;
      idle_enabled <= 1'b1;
      queue_pixel(24'hFFFFFF, 1'b1, 1'b1);
      queue_pixel(24'h000000, 1'b0, 1'b0);
      queue_pixel(24'h010203, 1'b1, 1'b0);
      wait_idle();

      // Empty prefix through a masked count, eight-byte suffix with a walking one.
      csr_write(CSR_PREFIX_BYTES, 64'h0000_0000_0000_0000);
      csr_write(CSR_PREFIX_COUNT, 64'hFFFF_FFFF_FFFF_FFF0);
      csr_write(CSR_SUFFIX_BYTES, 64'h8040_2010_0804_0201);
      csr_write(CSR_SUFFIX_COUNT, 64'h0000_0000_0000_0008);
      settings_used++;
      queue_pixel(24'h050505, 1'b0, 1'b0);
      queue_pixel(24'h050505, 1'b0, 1'b0);
      queue_pixel(24'h636363, 1'b0, 1'b1);
      wait_idle();

      // Random phases; the last one restores the reset strings and runs without idling.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < RANDOM_PHASES - 1) begin
            csr_write(CSR_PREFIX_BYTES, {$urandom, $urandom});
            csr_write(CSR_PREFIX_COUNT, {$urandom, $urandom});
            csr_write(CSR_SUFFIX_BYTES, {$urandom, $urandom});
            csr_write(CSR_SUFFIX_COUNT, {$urandom, $urandom});
         end else begin
            csr_write(CSR_PREFIX_BYTES, PREFIX_RESET);
            csr_write(CSR_PREFIX_COUNT, 64'(PREFIX_COUNT_RESET));
            csr_write(CSR_SUFFIX_BYTES, SUFFIX_RESET);
            csr_write(CSR_SUFFIX_COUNT, 64'(SUFFIX_COUNT_RESET));
         end
         settings_used++;
         idle_enabled <= (phase < RANDOM_PHASES - 1);
         queue_random_frames(PIXELS_PER_PHASE);
         if (phase == 1) begin
            @(posedge clock);
            stall_armed <= 1'b1;
         end
         wait_idle();
      end

      $display("Sent %0d pixels under %0d register settings (%0d writes);",
               pixels_sent, settings_used, csr_writes);
      $display("checked %0d text bytes across %0d frames, %0d mismatches.",
               chars_checked, frames_seen, mismatches);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("** pixel_to_ansi_truecolor_text: PASSED **");
      end else begin
         $display("** pixel_to_ansi_truecolor_text: FAILED **");
      end
      $finish;
   end

endmodule
